// ----- sv/stsnap_pkg.sv -----
// package: default sizes and operation codes for the sorted transaction id snapshot table
`default_nettype none

package stsnap_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 64;
	localparam int unsigned ID_WIDTH_DEF    = 48;

	localparam int unsigned OP_W = 2;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
	localparam logic [OP_W-1:0] OP_READ   = 2'd3;

endpackage

`default_nettype wire

// ----- sv/stsnap_ram.sv -----
// simple dual port memory holding the sorted ids, one write and one registered read port
`default_nettype none

module stsnap_ram #(
	parameter int unsigned DEPTH = stsnap_pkg::TABLE_DEPTH_DEF,
	parameter int unsigned WIDTH = stsnap_pkg::ID_WIDTH_DEF,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/sorted_txn_id_snapshot_table.sv -----
// top level: sequencer over the id memory with the result register
//
// Request channel (req_valid / req_stall) carries one transaction: operation, value, index.
// Response channel (rsp_valid / rsp_stall) returns one transaction per request:
// result_value, entry_count and overflow.
// operations: clear starts a view (both limits set, table emptied), insert places an id
// after any equal ids and lowers the up limit, query returns the first id above a limit
// or the low limit, read returns the entry at an index (0 beyond the count).
// States from acceptance to the result register, with no stall on the response side:
//   clear, full insert, insert into an empty table, empty query, read beyond count: S_START
//   read: S_START issues the memory read, S_RD returns the entry
//   query: S_START, then S_QRY examines entries in order (at most entry_count)
//   insert: S_START, then S_INS shifts entries up by one (at most entry_count), S_INS0 if all move
// The query and insert walks read one memory entry per cycle on the read port unless a
// stalled response holds them; on insert the write port moves the previous entry up.
// Only one request is in progress at a time; a new one is accepted as soon as the
// previous result sits in the response register, even while that is stalled.
// A stalled response freezes the sequencer until the register can take the next result.
// After reset the table is empty and both limits are zero; the memory needs no clearing.
`default_nettype none

module sorted_txn_id_snapshot_table #(
	parameter int unsigned TABLE_DEPTH = stsnap_pkg::TABLE_DEPTH_DEF,
	parameter int unsigned ID_WIDTH    = stsnap_pkg::ID_WIDTH_DEF,
	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	output logic                            req_stall,
	input  wire logic [stsnap_pkg::OP_W-1:0] operation,
	input  wire logic [ID_WIDTH-1:0]        value,
	input  wire logic [AW-1:0]              index,
	output logic                            rsp_valid,
	input  wire logic                       rsp_stall,
	output logic      [ID_WIDTH-1:0]        result_value,
	output logic      [CW-1:0]              entry_count,
	output logic                            overflow
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_INS   = 3'd2;
	localparam logic [2:0] S_INS0  = 3'd3;
	localparam logic [2:0] S_QRY   = 3'd4;
	localparam logic [2:0] S_RD    = 3'd5;

	logic [2:0]                  state_q, state_d;
	logic [stsnap_pkg::OP_W-1:0] op_q;
	logic [ID_WIDTH-1:0]         val_q;
	logic [AW-1:0]               idx_q;
	logic [CW-1:0]               count_q, count_d;
	logic [ID_WIDTH-1:0]         low_q, low_d;
	logic [ID_WIDTH-1:0]         up_q, up_d;
	logic [ID_WIDTH-1:0]         head_q, head_d;
	logic [AW-1:0]               d_q, d_d;

	logic                        we, re;
	logic [AW-1:0]               waddr, raddr;
	logic [ID_WIDTH-1:0]         wdata, rdata;

	logic                        fin, fin_ovf;
	logic [ID_WIDTH-1:0]         fin_value;
	logic                        can_load, accept;
	logic [ID_WIDTH-1:0]         ins_head, ins_up;
	logic [CW-1:0]               last_idx;

	logic                        rsp_valid_q;
	logic [ID_WIDTH-1:0]         result_value_q;
	logic [CW-1:0]               entry_count_q;
	logic                        overflow_q;

	stsnap_ram #(
		.DEPTH(TABLE_DEPTH),
		.WIDTH(ID_WIDTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign can_load  = !rsp_valid_q || !rsp_stall;

	// smallest entry and up limit once the pending id is in
	assign ins_head = ((count_q == '0) || (val_q < head_q)) ? val_q : head_q;
	assign ins_up   = (ins_head < up_q) ? ins_head : up_q;
	assign last_idx = count_q - CW'(1);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		low_d     = low_q;
		up_d      = up_q;
		head_d    = head_q;
		d_d       = d_q;
		we        = 1'b0;
		waddr     = AW'(d_q + AW'(1));
		wdata     = rdata;
		re        = 1'b0;
		raddr     = d_q;
		fin       = 1'b0;
		fin_value = up_q;
		fin_ovf   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_START;
				end
			end
			S_START: begin
				if (can_load) begin
					case (op_q)
						stsnap_pkg::OP_CLEAR: begin
							low_d     = val_q;
							up_d      = val_q;
							count_d   = '0;
							fin       = 1'b1;
							fin_value = val_q;
						end
						stsnap_pkg::OP_INSERT: begin
							if (count_q == CW'(TABLE_DEPTH)) begin
								fin     = 1'b1;
								fin_ovf = 1'b1;
							end else if (count_q == '0) begin
								we        = 1'b1;
								waddr     = '0;
								wdata     = val_q;
								count_d   = CW'(1);
								head_d    = ins_head;
								up_d      = ins_up;
								fin       = 1'b1;
								fin_value = ins_up;
							end else begin
								re      = 1'b1;
								raddr   = last_idx[AW-1:0];
								d_d     = last_idx[AW-1:0];
								state_d = S_INS;
							end
						end
						stsnap_pkg::OP_QUERY: begin
							if (count_q == '0) begin
								fin       = 1'b1;
								fin_value = low_q;
							end else begin
								re      = 1'b1;
								raddr   = '0;
								d_d     = '0;
								state_d = S_QRY;
							end
						end
						stsnap_pkg::OP_READ: begin
							if (CW'(idx_q) < count_q) begin
								re      = 1'b1;
								raddr   = idx_q;
								state_d = S_RD;
							end else begin
								fin       = 1'b1;
								fin_value = '0;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_INS: begin
				if (can_load) begin
					we = 1'b1;
					if (rdata > val_q) begin
						// shift this entry up by one
						if (d_q == '0) begin
							state_d = S_INS0;
						end else begin
							re    = 1'b1;
							raddr = AW'(d_q - AW'(1));
							d_d   = AW'(d_q - AW'(1));
						end
					end else begin
						wdata     = val_q;
						count_d   = count_q + CW'(1);
						head_d    = ins_head;
						up_d      = ins_up;
						fin       = 1'b1;
						fin_value = ins_up;
					end
				end
			end
			S_INS0: begin
				if (can_load) begin
					we        = 1'b1;
					waddr     = '0;
					wdata     = val_q;
					count_d   = count_q + CW'(1);
					head_d    = ins_head;
					up_d      = ins_up;
					fin       = 1'b1;
					fin_value = ins_up;
				end
			end
			S_QRY: begin
				if (can_load) begin
					if (rdata > val_q) begin
						fin       = 1'b1;
						fin_value = rdata;
					end else if (CW'(d_q) == last_idx) begin
						fin       = 1'b1;
						fin_value = low_q;
					end else begin
						re    = 1'b1;
						raddr = AW'(d_q + AW'(1));
						d_d   = AW'(d_q + AW'(1));
					end
				end
			end
			S_RD: begin
				if (can_load) begin
					fin       = 1'b1;
					fin_value = rdata;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) begin
			state_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			low_q       <= '0;
			up_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			low_q   <= low_d;
			up_q    <= up_d;
			if (can_load) begin
				rsp_valid_q <= fin;
			end
		end
	end

	// request and walk registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			val_q <= value;
			idx_q <= index;
		end
		head_q <= head_d;
		d_q    <= d_d;
	end

	// response register
	always_ff @(posedge clk) begin
		if (fin) begin
			result_value_q <= fin_value;
			entry_count_q  <= count_d;
			overflow_q     <= fin_ovf;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign result_value = result_value_q;
	assign entry_count  = entry_count_q;
	assign overflow     = overflow_q;

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// testbench for the sorted transaction id snapshot table: randomised view sequences
`timescale 1ns / 1ps

module tb_top;

	localparam int DEPTH = stsnap_pkg::TABLE_DEPTH_DEF;
	localparam int ID_W  = stsnap_pkg::ID_WIDTH_DEF;
	localparam int OPC_W = stsnap_pkg::OP_W;
	localparam int IX_W  = $clog2(DEPTH);
	localparam int CN_W  = $clog2(DEPTH + 1);
	localparam int ITEMS = 1050;
	localparam int CYCLE_LIMIT = 600000;
	localparam int TAIL_CYCLES = 100;

	typedef struct {
		logic [OPC_W-1:0] op;
		logic [ID_W-1:0]  val;
		logic [IX_W-1:0]  idx;
	} view_req_t;

	typedef struct {
		logic [ID_W-1:0] val;
		logic [CN_W-1:0] cnt;
		logic            ovf;
	} view_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [OPC_W-1:0] operation = stsnap_pkg::OP_CLEAR;
	logic [ID_W-1:0] value = '0;
	logic [IX_W-1:0] index = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [ID_W-1:0] result_value;
	logic [CN_W-1:0] entry_count;
	logic overflow;

	sorted_txn_id_snapshot_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.operation(operation),
		.value(value),
		.index(index),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.result_value(result_value),
		.entry_count(entry_count),
		.overflow(overflow)
	);

	// local view state
	logic [ID_W-1:0] id_tab [DEPTH];
	int              held_n = 0;
	logic [ID_W-1:0] low_lim = '0;
	logic [ID_W-1:0] up_lim = '0;

	view_req_t    pending_reqs [$];
	view_result_t expected_results [$];

	// generator-side tracking of the table fill
	int              gen_cnt = 0;
	logic [ID_W-1:0] gen_ids [$];

	bit req_taken = 1'b0;
	int req_gap = 0;
	int stall_left = 0;
	int taken_n = 0;
	int err_n = 0;
	int cyc_n = 0;
	int n_clear = 0, n_insert = 0, n_drop = 0, n_query = 0, n_read = 0, peak_cnt = 0;

	function automatic logic [ID_W-1:0] rand_id();
		logic [63:0] t;
		t = {$urandom, $urandom};
		return t[ID_W-1:0];
	endfunction

	function automatic view_result_t snapshot_step(logic [OPC_W-1:0] op, logic [ID_W-1:0] v,
			logic [IX_W-1:0] idx);
		view_result_t r;
		int i;
		int pos;
		bit found;
		r.ovf = 1'b0;
		found = 1'b0;
		case (op)
		stsnap_pkg::OP_CLEAR: begin
			low_lim = v;
			up_lim = v;
			held_n = 0;
			r.val = v;
		end
		stsnap_pkg::OP_INSERT: begin
			if (held_n >= DEPTH) begin
				r.val = up_lim;
				r.ovf = 1'b1;
			end else begin
				pos = held_n;
				for (i = 0; i < held_n; i++) begin
					if (!found && id_tab[i] > v) begin
						pos = i;
						found = 1'b1;
					end
				end
				for (i = held_n; i > pos; i--)
					id_tab[i] = id_tab[i-1];
				id_tab[pos] = v;
				held_n++;
				if (id_tab[0] < up_lim)
					up_lim = id_tab[0];
				r.val = up_lim;
			end
		end
		stsnap_pkg::OP_QUERY: begin
			r.val = low_lim;
			for (i = 0; i < held_n; i++) begin
				if (!found && id_tab[i] > v) begin
					r.val = id_tab[i];
					found = 1'b1;
				end
			end
		end
		default: begin
			r.val = (int'(idx) < held_n) ? id_tab[idx] : '0;
		end
		endcase
		r.cnt = CN_W'(held_n);
		return r;
	endfunction

	task automatic queue_req(input logic [OPC_W-1:0] op, input logic [ID_W-1:0] v,
			input logic [IX_W-1:0] idx);
		view_req_t t;
		t.op = op;
		t.val = v;
		t.idx = idx;
		pending_reqs.insert(pending_reqs.size(), t);
		if (op == stsnap_pkg::OP_CLEAR) begin
			gen_cnt = 0;
			gen_ids.delete();
		end else if (op == stsnap_pkg::OP_INSERT && gen_cnt < DEPTH) begin
			gen_cnt++;
			gen_ids.insert(gen_ids.size(), v);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// request driver
	always @(negedge clk) begin : req_drive
		view_req_t nxt;
		bit calm;
		calm = pending_reqs.size() < 120 || (pending_reqs.size() / 90) % 4 == 2;
		if (arst_n && (!req_valid || req_taken)) begin
			if (req_gap == 0 && !calm && $urandom_range(0, 5) == 0)
				req_gap = $urandom_range(1, 9);
			if (req_gap > 0 || pending_reqs.size() == 0) begin
				if (req_gap > 0)
					req_gap--;
				req_valid <= 1'b0;
			end else begin
				nxt = pending_reqs.pop_front();
				req_valid <= 1'b1;
				operation <= nxt.op;
				value <= nxt.val;
				index <= nxt.idx;
			end
		end
	end

	// response back-pressure
	always @(negedge clk) begin : rsp_drive
		bit calm;
		calm = pending_reqs.size() < 120 || (pending_reqs.size() / 90) % 4 == 1;
		if (stall_left == 0 && !calm && $urandom_range(0, 6) == 0)
			stall_left = $urandom_range(1, 9);
		if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// monitor: predicts on acceptance, checks each returned transaction
	always @(posedge clk) begin : txn_monitor
		view_result_t want;
		req_taken = arst_n && req_valid && !req_stall;
		if (req_taken) begin
			want = snapshot_step(operation, value, index);
			expected_results.insert(expected_results.size(), want);
			taken_n++;
			case (operation)
			stsnap_pkg::OP_CLEAR:  n_clear++;
			stsnap_pkg::OP_INSERT: begin
				n_insert++;
				if (want.ovf)
					n_drop++;
			end
			stsnap_pkg::OP_QUERY:  n_query++;
			default:               n_read++;
			endcase
			if (int'(want.cnt) > peak_cnt)
				peak_cnt = int'(want.cnt);
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected transaction, result_value %h entry_count %0d overflow %0b",
					$time, result_value, entry_count, overflow);
				err_n++;
			end else begin
				want = expected_results.pop_front();
				if (result_value !== want.val) begin
					$display("%0t: result_value expected %h actual %h", $time, want.val,
						result_value);
					err_n++;
				end
				if (entry_count !== want.cnt) begin
					$display("%0t: entry_count expected %0d actual %0d", $time, want.cnt,
						entry_count);
					err_n++;
				end
				if (overflow !== want.ovf) begin
					$display("%0t: overflow expected %0b actual %0b", $time, want.ovf, overflow);
					err_n++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cyc_n++;
		if (cyc_n > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d transactions still outstanding", $time,
				expected_results.size());
			$display("sorted_txn_id_snapshot_table: mismatch");
			$finish;
		end
	end

	initial begin
		logic [ID_W-1:0] mx;
		logic [ID_W-1:0] v;
		logic [IX_W-1:0] idx;
		int total;
		int seq_no;
		int span;
		int ins_n;
		int pick;

		// directed: empty table, duplicates, extremes, read past the end
		queue_req(stsnap_pkg::OP_QUERY, 48'h0000_0000_1234, '0);
		queue_req(stsnap_pkg::OP_READ, '1, '0);
		queue_req(stsnap_pkg::OP_INSERT, 48'd5, '1);
		queue_req(stsnap_pkg::OP_READ, '0, '0);
		queue_req(stsnap_pkg::OP_CLEAR, '1, '1);
		queue_req(stsnap_pkg::OP_INSERT, '1, '0);
		queue_req(stsnap_pkg::OP_INSERT, '0, '0);
		queue_req(stsnap_pkg::OP_INSERT, 48'd100, '0);
		queue_req(stsnap_pkg::OP_INSERT, 48'd100, '0);
		queue_req(stsnap_pkg::OP_INSERT, 48'd50, '0);
		queue_req(stsnap_pkg::OP_QUERY, '0, '0);
		queue_req(stsnap_pkg::OP_QUERY, 48'd49, '0);
		queue_req(stsnap_pkg::OP_QUERY, 48'd100, '0);
		queue_req(stsnap_pkg::OP_QUERY, '1, '0);
		queue_req(stsnap_pkg::OP_READ, '0, 6'd0);
		queue_req(stsnap_pkg::OP_READ, '0, 6'd3);
		queue_req(stsnap_pkg::OP_READ, '0, 6'd4);
		queue_req(stsnap_pkg::OP_READ, '0, 6'd5);
		queue_req(stsnap_pkg::OP_READ, '0, '1);
		queue_req(stsnap_pkg::OP_CLEAR, '0, '0);
		queue_req(stsnap_pkg::OP_INSERT, 48'd3, '0);
		queue_req(stsnap_pkg::OP_QUERY, 48'd3, '0);
		queue_req(stsnap_pkg::OP_READ, '1, '1);

		// random views: a clear, then inserts mixed with queries and reads
		seq_no = 0;
		while (pending_reqs.size() < ITEMS) begin
			case ($urandom_range(0, 3))
			0: mx = rand_id();
			1: mx = '1;
			2: mx = ID_W'($urandom_range(0, 1000));
			default: mx = rand_id() | {1'b1, {(ID_W-1){1'b0}}};
			endcase
			queue_req(stsnap_pkg::OP_CLEAR, mx, IX_W'($urandom));
			span = (seq_no % 3 == 0) ? $urandom_range(64, 70) : $urandom_range(1, 24);
			seq_no++;
			ins_n = 0;
			while (ins_n < span && pending_reqs.size() < ITEMS) begin
				pick = $urandom_range(0, 39);
				if (pick == 0) begin
					queue_req(OPC_W'($urandom), rand_id(), IX_W'($urandom));
				end else if (pick < 24) begin
					case ($urandom_range(0, 4))
					0: v = (gen_ids.size() > 0) ?
						gen_ids[$urandom_range(0, gen_ids.size() - 1)] : rand_id();
					1: v = rand_id();
					2: v = (mx > 1000) ? mx - ID_W'($urandom_range(0, 1000)) :
						ID_W'($urandom_range(0, 1000));
					3: v = ID_W'($urandom_range(0, 255));
					default: v = mx + ID_W'($urandom_range(0, 3));
					endcase
					queue_req(stsnap_pkg::OP_INSERT, v, IX_W'($urandom));
					ins_n++;
				end else if (pick < 32) begin
					case ($urandom_range(0, 4))
					0: v = '0;
					1: v = '1;
					2: v = rand_id();
					default: v = (gen_ids.size() > 0) ?
						gen_ids[$urandom_range(0, gen_ids.size() - 1)] +
						ID_W'($urandom_range(0, 2)) - ID_W'(1) : rand_id();
					endcase
					queue_req(stsnap_pkg::OP_QUERY, v, IX_W'($urandom));
				end else begin
					idx = ($urandom_range(0, 4) == 0) ? IX_W'($urandom) :
						IX_W'($urandom_range(0, gen_cnt));
					queue_req(stsnap_pkg::OP_READ, rand_id(), idx);
				end
			end
		end
		total = pending_reqs.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!(taken_n == total && expected_results.size() == 0))
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d transactions: %0d clears, %0d inserts",
			taken_n, n_clear, n_insert);
		$display("(%0d dropped on a full table), %0d queries and %0d reads; largest table %0d ids",
			n_drop, n_query, n_read, peak_cnt);
		if (err_n == 0) begin
			$display("sorted_txn_id_snapshot_table: match");
		end else begin
			$display("sorted_txn_id_snapshot_table: mismatch");
		end
		$finish;
	end

endmodule
